// ===== rtl/s2d_pkg.sv =====
// ----------------------------------------------------------------------------
// s2d_pkg
// Shared widths, character codes and BCD conversion constants.
// ----------------------------------------------------------------------------
package s2d_pkg;

  localparam int DIGIT_W      = 4;   // one BCD digit
  localparam int CODE_W       = 7;   // ASCII code
  localparam int TEXT_LEN_W   = 4;   // reported run length
  localparam int DABBLE_STEPS = 4;   // shift-and-add steps per conversion stage

  localparam logic [CODE_W-1:0] CHAR_ZERO  = 7'd48;  // '0'
  localparam logic [CODE_W-1:0] CHAR_NINE  = 7'd57;  // '9'
  localparam logic [CODE_W-1:0] CHAR_MINUS = 7'd45;  // '-'

  // Double dabble: a digit of five or more gets three added before the shift,
  // so that it carries into the next decade after doubling (radix ten).
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;

  typedef logic [DIGIT_W-1:0] digit_t;

endpackage

// ===== rtl/s2d_if.sv =====
// ----------------------------------------------------------------------------
// s2d_in_if / s2d_out_if
// Valid/ready channels: integer words in, character words out.
// ----------------------------------------------------------------------------
interface s2d_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface s2d_out_if
  import s2d_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CODE_W-1:0]     char_code;
  logic [TEXT_LEN_W-1:0] text_length;
  logic                  last_char;

  modport source (output valid, output char_code, output text_length, output last_char,
                  input ready);
  modport sink   (input valid, input char_code, input text_length, input last_char,
                  output ready);
endinterface

// ===== rtl/s2d_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// s2d_dabble_stage
// One registered slice of the binary-to-BCD shift-and-add-three conversion.
// ----------------------------------------------------------------------------
module s2d_dabble_stage
  import s2d_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int NDIG        = 10,
  parameter int STEPS       = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          neg_i,
  input  logic [NDIG-1:0][DIGIT_W-1:0]  bcd_i,
  input  logic [VALUE_WIDTH-1:0]        bin_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic                          neg_o,
  output logic [NDIG-1:0][DIGIT_W-1:0]  bcd_o,
  output logic [VALUE_WIDTH-1:0]        bin_o
);

  logic                         valid_q;
  logic                         neg_q;
  logic [NDIG-1:0][DIGIT_W-1:0] bcd_q, bcd_d;
  logic [VALUE_WIDTH-1:0]       bin_q, bin_d;
  logic                         adv;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  always_comb begin
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_d[d] >= DABBLE_LIMIT) begin
          bcd_d[d] = digit_t'(bcd_d[d] + DABBLE_ADJ);
        end
      end
      {bcd_d, bin_d} = {bcd_d, bin_d} << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      neg_q <= neg_i;
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;

endmodule

// ===== rtl/s2d_serialiser.sv =====
// ----------------------------------------------------------------------------
// s2d_serialiser
// Finds the text length, then emits sign and digits one character per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module s2d_serialiser
  import s2d_pkg::*;
#(
  parameter int NDIG = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic                         neg_i,
  input  logic [NDIG-1:0][DIGIT_W-1:0] bcd_i,
  s2d_out_if.source                    out_o
);

  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int LEN_W = $clog2(NDIG + 2);

  // length stage
  logic                         a_vld_q, a_neg_q, a_rdy;
  logic [NDIG-1:0][DIGIT_W-1:0] a_bcd_q;
  logic [IDX_W-1:0]             a_top_q, top_d;
  logic [LEN_W-1:0]             a_len_q, len_d;

  // emitter
  logic                         e_busy_q, e_sign_q;
  logic [IDX_W-1:0]             e_idx_q;
  logic [NDIG-1:0][DIGIT_W-1:0] e_bcd_q;
  logic [LEN_W-1:0]             e_len_q;
  logic                         load_e, emit, cur_last;
  logic [CODE_W-1:0]            cur_char;

  // output register
  logic                         o_vld_q, o_last_q, o_adv;
  logic [CODE_W-1:0]            o_char_q;
  logic [TEXT_LEN_W-1:0]        o_len_q;

  // highest non-zero digit; zero keeps index 0 and prints '0'
  always_comb begin
    top_d = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_i[d] != '0) begin
        top_d = IDX_W'(d);
      end
    end
    len_d = LEN_W'(LEN_W'(top_d) + LEN_W'(1) + LEN_W'(neg_i));
  end

  assign a_rdy   = !a_vld_q || load_e;
  assign ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_rdy) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && valid_i) begin
      a_neg_q <= neg_i;
      a_bcd_q <= bcd_i;
      a_top_q <= top_d;
      a_len_q <= len_d;
    end
  end

  assign o_adv    = !o_vld_q || out_o.ready;
  assign cur_last = !e_sign_q && (e_idx_q == '0);
  assign emit     = e_busy_q && o_adv;
  assign load_e   = a_vld_q && (!e_busy_q || (emit && cur_last));
  assign cur_char = e_sign_q ? CHAR_MINUS
                             : CODE_W'(CHAR_ZERO + CODE_W'(e_bcd_q[e_idx_q]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_busy_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (load_e) begin
        e_busy_q <= 1'b1;
      end else if (emit && cur_last) begin
        e_busy_q <= 1'b0;
      end
      if (o_adv) begin
        o_vld_q <= e_busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_e) begin
      e_sign_q <= a_neg_q;
      e_idx_q  <= a_top_q;
      e_bcd_q  <= a_bcd_q;
      e_len_q  <= a_len_q;
    end else if (emit) begin
      if (e_sign_q) begin
        e_sign_q <= 1'b0;
      end else begin
        e_idx_q <= IDX_W'(e_idx_q - IDX_W'(1));
      end
    end
    if (emit) begin
      o_char_q <= cur_char;
      o_len_q  <= TEXT_LEN_W'(e_len_q);
      o_last_q <= cur_last;
    end
  end

  assign out_o.valid       = o_vld_q;
  assign out_o.char_code   = o_char_q;
  assign out_o.text_length = o_len_q;
  assign out_o.last_char   = o_last_q;

  // only the sign or a decimal digit ever leaves
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q |-> (o_char_q == CHAR_MINUS) ||
                ((o_char_q >= CHAR_ZERO) && (o_char_q <= CHAR_NINE)))
    else $error("s2d_serialiser: character out of set");

  // the sign always has digits after it
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && (o_char_q == CHAR_MINUS)) |-> !o_last_q)
    else $error("s2d_serialiser: sign flagged as last");

  // the length stage's text length lies between 1 and NDIG + 1
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> (a_len_q >= LEN_W'(1)) && (a_len_q <= LEN_W'(NDIG + 1)))
    else $error("s2d_serialiser: text length out of range");

  // an emitted digit follows the previous one down to the units digit
  a_idx_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !cur_last && !e_sign_q && !load_e) |=> (e_idx_q == $past(e_idx_q) - IDX_W'(1)))
    else $error("s2d_serialiser: digit index skipped");

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character word per handshake.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                                   | handshake
//  --------+-----+----------------------------------------+------------------
//  in_i    | in  | value (VALUE_WIDTH, signed)            | valid && ready
//  out_o   | out | char_code(7) text_length(4) last_char  | valid && ready
//
//  Path: input register, ceil(VALUE_WIDTH/4) conversion stages (8 at 32
//  bits), length stage, emitter and output register.
//  Rate: one character word per cycle at the output while out_o is not stalled;
//  an item is text_length words long (1 to 11 at 32 bits); the single emitter sets the rate.
//  Reset clears only valid and busy flags; no clearing pass.
//  Stalls on out_o back up stage by stage; no word is lost or repeated.
//
module signed_int_to_decimal_ascii
  import s2d_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  s2d_in_if.sink    in_i,
  s2d_out_if.source out_o
);

  // digit count enough for 2^(VALUE_WIDTH-1): log10(2) is a little under 0.31
  localparam int NDIG  = (VALUE_WIDTH * 31) / 100 + 1;
  localparam int STEPS = DABBLE_STEPS;
  localparam int NSTG  = (VALUE_WIDTH + STEPS - 1) / STEPS;

  // input stage: sign and unsigned magnitude (most negative value is exact)
  logic                   in_vld_q, in_neg_q, in_rdy, neg_d;
  logic [VALUE_WIDTH-1:0] in_mag_q, mag_d;

  // conversion pipeline taps
  logic                         st_vld [NSTG+1];
  logic                         st_rdy [NSTG+1];
  logic                         st_neg [NSTG+1];
  logic [NDIG-1:0][DIGIT_W-1:0] st_bcd [NSTG+1];
  logic [VALUE_WIDTH-1:0]       st_bin [NSTG+1];

  assign neg_d  = in_i.value[VALUE_WIDTH-1];
  assign mag_d  = neg_d ? VALUE_WIDTH'(~in_i.value + VALUE_WIDTH'(1))
                        : VALUE_WIDTH'(in_i.value);
  assign in_rdy = !in_vld_q || st_rdy[0];
  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      in_neg_q <= neg_d;
      in_mag_q <= mag_d;
    end
  end

  assign st_vld[0] = in_vld_q;
  assign st_neg[0] = in_neg_q;
  assign st_bcd[0] = '0;
  assign st_bin[0] = in_mag_q;

  // shift-and-add-three, STEPS bits per stage; the last stage takes the rest
  for (genvar k = 0; k < NSTG; k++) begin : g_dabble
    localparam int S = (k == NSTG - 1) ? VALUE_WIDTH - STEPS * (NSTG - 1) : STEPS;

    s2d_dabble_stage #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NDIG        (NDIG),
      .STEPS       (S)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_vld[k]),
      .ready_o (st_rdy[k]),
      .neg_i   (st_neg[k]),
      .bcd_i   (st_bcd[k]),
      .bin_i   (st_bin[k]),
      .valid_o (st_vld[k+1]),
      .ready_i (st_rdy[k+1]),
      .neg_o   (st_neg[k+1]),
      .bcd_o   (st_bcd[k+1]),
      .bin_o   (st_bin[k+1])
    );
  end

  // length stage and character emitter
  s2d_serialiser #(
    .NDIG (NDIG)
  ) u_serialiser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_vld[NSTG]),
    .ready_o (st_rdy[NSTG]),
    .neg_i   (st_neg[NSTG]),
    .bcd_i   (st_bcd[NSTG]),
    .out_o   (out_o)
  );

  // all binary bits have been shifted into the digits by the last stage
  a_bin_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_vld[NSTG] |-> (st_bin[NSTG] == '0))
    else $error("signed_int_to_decimal_ascii: conversion not drained");

  // a captured magnitude never exceeds 2^(VALUE_WIDTH-1)
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && in_mag_q[VALUE_WIDTH-1]) |-> (in_mag_q[VALUE_WIDTH-2:0] == '0) && in_neg_q)
    else $error("signed_int_to_decimal_ascii: magnitude out of range");

  // the input stage holds its word while the first pipeline stage is not ready
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !st_rdy[0]) |=> in_vld_q && $stable(in_mag_q))
    else $error("signed_int_to_decimal_ascii: input stage dropped a word");

endmodule
